### src/bpca_pkg.sv
// Shared types and constants for the battery power command arbiter.
package bpca_pkg;

    // Serial multiplier geometry: multiplicand, multiplier and product widths
    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 24;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHARGE_LIMIT     = 3'd0,
        REG_DISCHARGE_LIMIT  = 3'd1,
        REG_CHARGE_ENABLE    = 3'd2,
        REG_DISCHARGE_ENABLE = 3'd3,
        REG_SLEW_LIMIT       = 3'd4,
        REG_FILTER_ALPHA     = 3'd5,
        REG_SOC_GAIN         = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        MD_SMOOTH    = 2'd0,
        MD_CHARGE    = 2'd1,
        MD_DISCHARGE = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_MUL,
        ST_FILT_RND,
        ST_FILT_UPD,
        ST_DECIDE,
        ST_SLEW,
        ST_SOC_START,
        ST_SOC_MUL,
        ST_SOC_RND,
        ST_SOC_UPD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    localparam logic [22:0] CHARGE_LIMIT_RST    = 23'd38400;
    localparam logic [22:0] DISCHARGE_LIMIT_RST = 23'd38400;
    localparam logic [22:0] SLEW_LIMIT_RST      = 23'd2560;
    localparam logic [16:0] FILTER_ALPHA_RST    = 17'd19661;
    localparam logic [31:0] SOC_GAIN_RST        = 32'd3054188;

    localparam logic [16:0] ALPHA_ONE = 17'h10000;
    localparam logic signed [23:0] REVERSE_TRIP = 24'sd128;
    localparam logic signed [23:0] DEMAND_TRIP  = 24'sd2560;

    localparam logic [38:0] LEVEL_MIN   = 39'd42949672960;
    localparam logic [38:0] LEVEL_MAX   = 39'd386547056640;
    localparam logic [38:0] LEVEL_RESET = 39'd214748364800;

endpackage

### src/battery_power_command_arbiter_unit.sv
// Top level: filter, mode arbitration, command limiting and charge-state tracking.
// A new word is accepted only in the idle state, once the last one has been loaded
// into the output register, which waits for out_ready while it is still full.
// Both products (filter and charge state) run through one bit-serial multiplier.
// Reset: asynchronous, active low; registers to defaults, filter and command to
// zero, smooth mode, charge state at fifty percent.
module battery_power_command_arbiter_unit #(
    parameter int HOLD_TICKS = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [23:0]                reverse_request,
    input  logic signed [23:0]                demand_request,
    input  logic signed [23:0]                smooth_request,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [23:0]                battery_command,
    output logic [1:0]                        active_mode,
    output logic [38:0]                       charge_state,
    output logic signed [23:0]                filtered_reverse,
    input  logic                              cfg_write,
    input  logic [bpca_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bpca_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bpca_pkg::*;

    localparam int CNT_W = (HOLD_TICKS > 1) ? $clog2(HOLD_TICKS) : 1;
    localparam logic [CNT_W:0] SW_DELAY = (CNT_W + 1)'(HOLD_TICKS);

    function automatic logic signed [25:0] sx26(input logic signed [23:0] v);
        return {{2{v[23]}}, v};
    endfunction

    function automatic logic signed [25:0] clip26(input logic signed [25:0] v,
                                                  input logic signed [25:0] lo,
                                                  input logic signed [25:0] hi);
        logic signed [25:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    // Configuration registers
    logic [22:0] charge_limit_reg;
    logic [22:0] discharge_limit_reg;
    logic        charge_enable_reg;
    logic        discharge_enable_reg;
    logic [22:0] slew_limit_reg;
    logic [16:0] filter_alpha_reg;
    logic [31:0] soc_gain_reg;

    // Tick state
    logic signed [23:0] filt_reg;
    mode_t              mode_reg;
    logic [CNT_W-1:0]   count_reg;
    logic signed [23:0] last_cmd_reg;
    logic [38:0]        level_reg;

    // Working registers
    state_t             state_reg, state_next;
    logic signed [23:0] dem_reg;
    logic signed [23:0] smo_reg;
    logic               diff_neg_reg;
    logic [41:0]        rnd_reg;
    logic signed [23:0] cmd_pre_reg;
    logic [39:0]        delta_reg;

    // Output register
    logic               out_valid_reg;
    logic signed [23:0] out_cmd_reg;
    mode_t              out_mode_reg;
    logic [38:0]        out_level_reg;
    logic signed [23:0] out_filt_reg;

    // Control
    logic      accept;
    logic      mul_start;
    logic      out_load;
    mul_stat_t mul_stat;

    // Multiplier connections
    logic [MUL_A_W-1:0] mul_mcand;
    logic [MUL_B_W-1:0] mul_mplier;
    logic [MUL_P_W-1:0] mul_product;

    // Datapath combinational values
    logic signed [24:0] diff25;
    logic [24:0]        diff_mag;
    logic [23:0]        last_mag;
    logic [16:0]        alpha_eff;
    logic [40:0]        prod41;
    logic [41:0]        rnd_next;
    logic signed [25:0] filt_sum;
    logic               force_charge;
    mode_t              want_mode;
    mode_t              mode_next;
    logic [CNT_W:0]     count_inc;
    logic [CNT_W-1:0]   count_next;
    logic signed [25:0] f26, dem26, smo26, cl26, dl26, cmd26;
    logic signed [25:0] slew_lo, slew_hi, slew_cmd;
    logic [MUL_P_W-1:0] soc_sum;
    logic signed [41:0] lvl42, new_lvl, lmin42, lmax42;
    logic [38:0]        level_next;

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_limit_reg     <= CHARGE_LIMIT_RST;
            discharge_limit_reg  <= DISCHARGE_LIMIT_RST;
            charge_enable_reg    <= 1'b1;
            discharge_enable_reg <= 1'b1;
            slew_limit_reg       <= SLEW_LIMIT_RST;
            filter_alpha_reg     <= FILTER_ALPHA_RST;
            soc_gain_reg         <= SOC_GAIN_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_CHARGE_LIMIT:     charge_limit_reg     <= cfg_data[22:0];
                REG_DISCHARGE_LIMIT:  discharge_limit_reg  <= cfg_data[22:0];
                REG_CHARGE_ENABLE:    charge_enable_reg    <= cfg_data[0];
                REG_DISCHARGE_ENABLE: discharge_enable_reg <= cfg_data[0];
                REG_SLEW_LIMIT:       slew_limit_reg       <= cfg_data[22:0];
                REG_FILTER_ALPHA:     filter_alpha_reg     <= cfg_data[16:0];
                REG_SOC_GAIN:         soc_gain_reg         <= cfg_data;
                default:              ;
            endcase
        end
    end

    // ---------------------------------------------------------------- multiplier
    bpca_smul u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .product (mul_product),
        .stat    (mul_stat)
    );

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        diff25    = {reverse_request[23], reverse_request} - {filt_reg[23], filt_reg};
        diff_mag  = diff25[24] ? (~diff25 + 25'd1) : diff25;
        last_mag  = last_cmd_reg[23] ? (~last_cmd_reg + 24'd1) : last_cmd_reg;
        alpha_eff = filter_alpha_reg[16] ? ALPHA_ONE : filter_alpha_reg;

        // Filter product first, charge-state product in its own start state
        if (state_reg == ST_SOC_START)
        begin
            mul_mcand  = soc_gain_reg;
            mul_mplier = last_mag;
        end
        else
        begin
            mul_mcand  = {15'd0, alpha_eff};
            mul_mplier = diff_mag[23:0];
        end

        // Signed product plus half, negate as one's complement plus one
        prod41   = mul_product[40:0];
        rnd_next = (diff_neg_reg ? ~{1'b0, prod41} : {1'b0, prod41})
                   + 42'd32768 + {41'd0, diff_neg_reg};
        filt_sum = sx26(filt_reg) + $signed(rnd_reg[41:16]);

        // Mode arbitration
        force_charge = (filt_reg > REVERSE_TRIP);
        want_mode    = (dem_reg > DEMAND_TRIP) ? MD_DISCHARGE : MD_SMOOTH;
        count_inc    = {1'b0, count_reg} + 1'b1;
        mode_next    = mode_reg;
        count_next   = '0;
        if (force_charge)
        begin
            mode_next = MD_CHARGE;
        end
        else if (want_mode != mode_reg)
        begin
            if (count_inc >= SW_DELAY)
            begin
                mode_next = want_mode;
            end
            else
            begin
                count_next = count_inc[CNT_W-1:0];
            end
        end

        // Command of the chosen mode, gated and clamped
        f26   = sx26(filt_reg);
        dem26 = sx26(dem_reg);
        smo26 = sx26(smo_reg);
        cl26  = {3'b000, charge_limit_reg};
        dl26  = {3'b000, discharge_limit_reg};
        cmd26 = '0;
        if (force_charge)
        begin
            if (charge_enable_reg)
            begin
                cmd26 = clip26(-f26, -cl26, '0);
            end
        end
        else if (mode_next == MD_DISCHARGE)
        begin
            if (discharge_enable_reg)
            begin
                cmd26 = clip26(dem26, '0, dl26);
            end
        end
        else if (smo_reg[23])
        begin
            if (charge_enable_reg)
            begin
                cmd26 = clip26(smo26, -cl26, '0);
            end
        end
        else if (discharge_enable_reg)
        begin
            cmd26 = clip26(smo26, '0, dl26);
        end

        // Slew limit against the previous command
        slew_lo  = sx26(last_cmd_reg) - $signed({3'b000, slew_limit_reg});
        slew_hi  = sx26(last_cmd_reg) + $signed({3'b000, slew_limit_reg});
        slew_cmd = clip26(sx26(cmd_pre_reg), slew_lo, slew_hi);

        // Charge state moves against the command
        soc_sum = mul_product + MUL_P_W'(32768);
        lvl42   = {3'b000, level_reg};
        lmin42  = {3'b000, LEVEL_MIN};
        lmax42  = {3'b000, LEVEL_MAX};
        new_lvl = last_cmd_reg[23] ? (lvl42 + $signed({2'b00, delta_reg}))
                                   : (lvl42 - $signed({2'b00, delta_reg}));
        if (new_lvl < lmin42)
        begin
            level_next = LEVEL_MIN;
        end
        else if (new_lvl > lmax42)
        begin
            level_next = LEVEL_MAX;
        end
        else
        begin
            level_next = new_lvl[38:0];
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        mul_start  = 1'b0;
        out_load   = 1'b0;
        accept     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    accept     = 1'b1;
                    mul_start  = 1'b1;
                    state_next = ST_FILT_MUL;
                end
            end
            ST_FILT_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_FILT_RND;
                end
            end
            ST_FILT_RND:  state_next = ST_FILT_UPD;
            ST_FILT_UPD:  state_next = ST_DECIDE;
            ST_DECIDE:    state_next = ST_SLEW;
            ST_SLEW:      state_next = ST_SOC_START;
            ST_SOC_START:
            begin
                mul_start  = 1'b1;
                state_next = ST_SOC_MUL;
            end
            ST_SOC_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_SOC_RND;
                end
            end
            ST_SOC_RND:   state_next = ST_SOC_UPD;
            ST_SOC_UPD:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                // Hold until the previous word has left the output register
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Tick state, set to its defaults by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg     <= '0;
            mode_reg     <= MD_SMOOTH;
            count_reg    <= '0;
            last_cmd_reg <= '0;
            level_reg    <= LEVEL_RESET;
        end
        else
        begin
            if (state_reg == ST_FILT_UPD)
            begin
                filt_reg <= filt_sum[23:0];
            end
            if (state_reg == ST_DECIDE)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
            end
            if (state_reg == ST_SLEW)
            begin
                last_cmd_reg <= slew_cmd[23:0];
            end
            if (state_reg == ST_SOC_UPD)
            begin
                level_reg <= level_next;
            end
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dem_reg      <= demand_request;
            smo_reg      <= smooth_request;
            diff_neg_reg <= diff25[24];
        end
        if (state_reg == ST_FILT_RND)
        begin
            rnd_reg <= rnd_next;
        end
        if (state_reg == ST_DECIDE)
        begin
            cmd_pre_reg <= cmd26[23:0];
        end
        if (state_reg == ST_SOC_RND)
        begin
            delta_reg <= soc_sum[55:16];
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cmd_reg   <= last_cmd_reg;
            out_mode_reg  <= mode_reg;
            out_level_reg <= level_reg;
            out_filt_reg  <= filt_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign battery_command  = out_cmd_reg;
    assign active_mode      = out_mode_reg;
    assign charge_state     = out_level_reg;
    assign filtered_reverse = out_filt_reg;

    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        (level_reg >= LEVEL_MIN) && (level_reg <= LEVEL_MAX))
        else $error("charge state left its clamp range");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < SW_DELAY)
        else $error("switch counter reached the switch delay");

    a_ready_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mul_stat.busy)
        else $error("ready for a word while the multiplier is busy");

endmodule

### src/bpca_smul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
module bpca_smul (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bpca_pkg::MUL_A_W-1:0]   mcand,
    input  logic [bpca_pkg::MUL_B_W-1:0]   mplier,
    output logic [bpca_pkg::MUL_P_W-1:0]   product,
    output bpca_pkg::mul_stat_t            stat
);
    import bpca_pkg::*;

    localparam int CNT_W = $clog2(MUL_B_W);

    logic [MUL_P_W-1:0] acc_reg;
    logic [MUL_A_W-1:0] mcand_reg;
    logic [MUL_B_W-1:0] mplr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [MUL_P_W-1:0] acc_next;

    // Double the partial sum and add the multiplicand for the next bit
    always_comb
    begin
        acc_next = {acc_reg[MUL_P_W-2:0], 1'b0};
        if (mplr_reg[MUL_B_W-1])
        begin
            acc_next = acc_next + {{MUL_B_W{1'b0}}, mcand_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(MUL_B_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= '0;
            mcand_reg <= mcand;
            mplr_reg  <= mplier;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            mplr_reg <= {mplr_reg[MUL_B_W-2:0], 1'b0};
        end
    end

    assign product   = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && busy_reg))
        else $error("multiplier started while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("multiplier done while still busy");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("multiplier finished without done");

endmodule
